[design/fblm_pkg.sv]
// Shared types and constants for the free block list manager.
// Holds the command and result words and the controller/datapath interface structs.
// No dependencies.
package fblm_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int MAX_POP    = 64;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 7;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int LINK_W     = INDEX_W + 1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [INDEX_W-1:0] block_index;
        logic [COUNT_W-1:0] pop_count;
    } cmd_word_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] taken_index;
        logic               last;
    } result_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted command word
        logic push;        // link the captured block in front of the head
        logic read_head;   // read the link of the current head block
        logic emit_empty;  // show a not-found result
        logic emit_next;   // show the head block, advance, read the next link
    } fblm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pop;
        logic head_present;
        logic last_block;
    } fblm_status_t;

endpackage

[design/fblm_datapath.sv]
// Datapath of the free block list manager: head register, link memory,
// remaining-count register and the registered result word. Uses fblm_pkg.
module fblm_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fblm_pkg::cmd_word_t    cmd,
    input  fblm_pkg::fblm_cmd_t    ctrl,
    output fblm_pkg::fblm_status_t status,
    output logic                   result_valid,
    output fblm_pkg::result_word_t result
);

    logic [fblm_pkg::LINK_W-1:0]  link_mem [fblm_pkg::NUM_BLOCKS];
    logic [fblm_pkg::LINK_W-1:0]  link_rd_reg;
    fblm_pkg::cmd_word_t          req_reg;
    logic [fblm_pkg::INDEX_W-1:0] head_reg;
    logic [fblm_pkg::INDEX_W-1:0] head_next;
    logic                         present_reg;
    logic                         present_next;
    logic [fblm_pkg::COUNT_W-1:0] remain_reg;
    logic [fblm_pkg::COUNT_W-1:0] remain_next;
    logic [fblm_pkg::COUNT_W-1:0] want;
    logic                         result_valid_reg;
    fblm_pkg::result_word_t       result_reg;
    logic [fblm_pkg::ADDR_W-1:0]  rd_addr;
    logic                         push_ok;
    logic                         link_valid;

    // A request of zero means one; a request above the maximum saturates.
    always_comb
    begin
        if (cmd.pop_count == '0)
            want = fblm_pkg::COUNT_W'(1);
        else if (32'(cmd.pop_count) > fblm_pkg::MAX_POP)
            want = fblm_pkg::COUNT_W'(fblm_pkg::MAX_POP);
        else
            want = cmd.pop_count;
    end

    assign push_ok    = 32'(req_reg.block_index) < fblm_pkg::NUM_BLOCKS;
    assign link_valid = link_rd_reg[fblm_pkg::LINK_W-1];

    // While walking, the next read goes to the block named by the link just read.
    assign rd_addr = ctrl.emit_next ? link_rd_reg[fblm_pkg::ADDR_W-1:0]
                                    : head_reg[fblm_pkg::ADDR_W-1:0];

    always_comb
    begin
        head_next    = head_reg;
        present_next = present_reg;
        remain_next  = remain_reg;
        if (ctrl.load)
            remain_next = want;
        if (ctrl.push && push_ok)
        begin
            head_next    = req_reg.block_index;
            present_next = 1'b1;
        end
        if (ctrl.emit_next)
        begin
            present_next = link_valid;
            head_next    = link_valid ? link_rd_reg[fblm_pkg::INDEX_W-1:0] : '0;
            remain_next  = remain_reg - fblm_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg         <= '0;
            present_reg      <= 1'b0;
            remain_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg         <= head_next;
            present_reg      <= present_next;
            remain_reg       <= remain_next;
            result_valid_reg <= ctrl.emit_empty | ctrl.emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
            req_reg <= cmd;
        if (ctrl.emit_empty)
        begin
            result_reg.found       <= 1'b0;
            result_reg.taken_index <= '0;
            result_reg.last        <= 1'b1;
        end
        else if (ctrl.emit_next)
        begin
            result_reg.found       <= 1'b1;
            result_reg.taken_index <= head_reg;
            result_reg.last        <= status.last_block;
        end
    end

    // Link memory: one write port for pushes, one registered read port for walks.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && push_ok)
            link_mem[req_reg.block_index[fblm_pkg::ADDR_W-1:0]] <= {present_reg, head_reg};
        if (ctrl.read_head || ctrl.emit_next)
            link_rd_reg <= link_mem[rd_addr];
    end

    assign status.is_pop       = (req_reg.operation == fblm_pkg::OP_POP);
    assign status.head_present = present_reg;
    assign status.last_block   = (remain_reg == fblm_pkg::COUNT_W'(1)) || !link_valid;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[design/fblm_controller.sv]
// Controller state machine of the free block list manager.
// Sequences pushes and pop walks over the datapath. Uses fblm_pkg.
module fblm_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fblm_pkg::fblm_status_t status,
    output fblm_pkg::fblm_cmd_t    ctrl,
    output logic                   busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!status.is_pop)
                begin
                    ctrl.push  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!status.head_present)
                begin
                    ctrl.emit_empty = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    ctrl.read_head = 1'b1;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                ctrl.emit_next = 1'b1;
                if (status.last_block)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

[design/free_block_list_manager.sv]
// Top level of the free block list manager: a LIFO free list of block indices.
// Instantiates fblm_controller and fblm_datapath; uses fblm_pkg.
//
// Usage: a command word (cmd) is taken at a rising edge where start is high
// and busy is low. A push word links block_index in front of the list head
// and gives no result; it keeps busy high for one cycle after acceptance.
// A pop word walks from the head and emits up to pop_count blocks (zero
// counts as one, counts above the maximum saturate). Each result word is
// shown on result for exactly one cycle with result_valid high; the final
// word of a pop carries last. An empty list gives a single word with found
// low and last high.
// After acceptance the decode state reads the head block's link and the walk
// state registers the first pop result (decode does so for an empty list);
// further blocks follow one per cycle, since each link read from the
// synchronous link memory supplies the address of the next read. A pop stays
// busy for decode and a walk step per block; a push or empty pop for decode.
// The receiver cannot stall: result words are simply presented once.
// Reset empties the list; the link memory is not cleared, since only links
// written by earlier pushes are ever followed.
module free_block_list_manager (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  fblm_pkg::cmd_word_t    cmd,
    output logic                   busy,
    output logic                   result_valid,
    output fblm_pkg::result_word_t result
);

    fblm_pkg::fblm_cmd_t    ctrl;
    fblm_pkg::fblm_status_t status;

    // The controller only looks at start while idle, so busy gates acceptance.
    fblm_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    fblm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .ctrl         (ctrl),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    // A not-found word always ends its pop request.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.found |-> result.last)
        else $error("not-found result without last");

    // No result word can appear in the cycle right after a word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !result_valid)
        else $error("result too early after acceptance");

    // When the final word of a pop is shown, the block is already free again.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("busy still high at final result");

    // Walk commands only issue while busy, never alongside a load.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit_next |-> busy && !ctrl.load)
        else $error("walk step outside a pop");

endmodule

[tb/free_block_list_manager_test.sv]
// Self-checking testbench for the free block list manager (LIFO free list of block indices).
// Depends on fblm_pkg and free_block_list_manager; it predicts every result word itself.
`timescale 1ns / 100ps

module free_block_list_manager_test;

    // This limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT = 200000;
    // After the last expected word, keep watching for any stray output.
    localparam int TAIL_CYCLES = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    fblm_pkg::cmd_word_t    cmd;
    logic                   busy;
    logic                   result_valid;
    fblm_pkg::result_word_t result;

    free_block_list_manager dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    // Shadow copy of the free list. The head register has a presence bit. Each link
    // word holds a "next exists" bit above the index of the next block.
    logic [fblm_pkg::INDEX_W-1:0] shadow_head;
    logic                         shadow_head_valid;
    logic [fblm_pkg::LINK_W-1:0]  shadow_links [fblm_pkg::NUM_BLOCKS];

    // Tracks which blocks are currently free. The generator uses it to push only
    // blocks that are not on the list yet, the way a real allocator behaves.
    bit on_list [fblm_pkg::NUM_BLOCKS];
    int list_depth;

    // Result words that the block still owes, oldest first.
    fblm_pkg::result_word_t pending_results [$];

    int mismatches;
    int cycle_count;
    int pushes_sent;
    int pops_sent;
    int empty_pops;
    int capped_pops;
    int words_checked;

    // The sender works in bursts. When a burst runs out and gaps are enabled,
    // start drops for a random gap before the next burst begins.
    bit gaps_on;
    int burst_left;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog. A hung handshake or a lost word ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t ns: timeout after %0d cycles, %0d words still expected",
                     $realtime, cycle_count, pending_results.size());
            $display("free_block_list_manager_test NOT OK");
            $finish;
        end
    end

    function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $realtime, field, want, got);
            mismatches++;
        end
    endfunction

    // The receiver cannot hold results off, so every word with the strobe high is
    // taken at the edge that ends its cycle. The outputs are sampled before this
    // edge's updates land.
    always @(posedge clk)
    begin
        fblm_pkg::result_word_t want;
        if (rst_n === 1'b1 && result_valid !== 1'b0)
        begin
            if (result_valid !== 1'b1)
            begin
                $display("%0t ns: result_valid is unknown", $realtime);
                mismatches++;
            end
            else if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected word, expected none, %s found=%0b index=%0d last=%0b",
                         $realtime, "actual", result.found, result.taken_index,
                         result.last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("found", 8'(want.found), 8'(result.found));
                compare_field("taken_index", want.taken_index, result.taken_index);
                compare_field("last", 8'(want.last), 8'(result.last));
                words_checked++;
            end
        end
    end

    // Applies one accepted command to the shadow list. It queues the words that a pop
    // must produce. A pop walks from the head until the count is met or the list runs
    // dry. Popped blocks keep their links, so a block pushed twice forms a loop that
    // later pops follow until the count stops them.
    task automatic apply_list_command(input fblm_pkg::cmd_word_t w);
        int                          wanted;
        int                          taken;
        logic [fblm_pkg::LINK_W-1:0] next_link;
        fblm_pkg::result_word_t      word;
        if (w.operation == fblm_pkg::OP_PUSH)
        begin
            pushes_sent++;
            shadow_links[w.block_index] = {shadow_head_valid, shadow_head};
            shadow_head = w.block_index;
            shadow_head_valid = 1'b1;
            if (!on_list[w.block_index])
            begin
                on_list[w.block_index] = 1'b1;
                list_depth++;
            end
        end
        else
        begin
            pops_sent++;
            wanted = int'(w.pop_count);
            if (wanted == 0)
                wanted = 1;
            if (wanted > fblm_pkg::MAX_POP)
                wanted = fblm_pkg::MAX_POP;
            if (!shadow_head_valid)
            begin
                // An empty list gives one not-found word, marked last.
                word.found = 1'b0;
                word.taken_index = '0;
                word.last = 1'b1;
                pending_results.push_back(word);
                empty_pops++;
            end
            else
            begin
                taken = 0;
                while (shadow_head_valid && taken < wanted)
                begin
                    next_link = shadow_links[shadow_head];
                    word.found = 1'b1;
                    word.taken_index = shadow_head;
                    word.last = !next_link[fblm_pkg::LINK_W-1] || (taken + 1 == wanted);
                    pending_results.push_back(word);
                    if (on_list[shadow_head])
                    begin
                        on_list[shadow_head] = 1'b0;
                        list_depth--;
                    end
                    shadow_head_valid = next_link[fblm_pkg::LINK_W-1];
                    shadow_head = shadow_head_valid ? next_link[fblm_pkg::INDEX_W-1:0] : '0;
                    taken++;
                end
                if (taken == fblm_pkg::MAX_POP)
                    capped_pops++;
            end
        end
    endtask

    // Sends one command word. start stays high after acceptance. The next call either
    // keeps it high for the following word or drops it for a gap, so start gets one
    // assignment per time step. busy is sampled at the edge, before it updates.
    task automatic send_word(input fblm_pkg::cmd_word_t w);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        start <= 1'b1;
        cmd <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_list_command(w);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic push_block(input logic [fblm_pkg::INDEX_W-1:0] idx);
        fblm_pkg::cmd_word_t w;
        w.operation = fblm_pkg::OP_PUSH;
        w.block_index = idx;
        w.pop_count = 7'($urandom_range(0, 127));
        send_word(w);
    endtask

    task automatic pop_blocks(input logic [fblm_pkg::COUNT_W-1:0] count);
        fblm_pkg::cmd_word_t w;
        w.operation = fblm_pkg::OP_POP;
        w.block_index = 8'($urandom);
        w.pop_count = count;
        send_word(w);
    endtask

    // Holds start low until every owed word has arrived. The loop waits on the clock
    // before each check, so a following send never assigns start in the same step.
    task automatic drain_results;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Pops on a list that has never been filled. Zero, one, the maximum and the
    // largest count that fits must all give the single not-found word.
    task automatic test_empty_list;
        gaps_on = 1'b0;
        pop_blocks(7'd0);
        pop_blocks(7'd1);
        pop_blocks(7'(fblm_pkg::MAX_POP));
        pop_blocks(7'h7F);
        drain_results();
    endtask

    // LIFO order using the extreme indices. The pop with count 64 runs out
    // after two blocks, and the pop after it finds the list empty again.
    task automatic test_push_pop_order;
        gaps_on = 1'b1;
        burst_left = 2;
        push_block(8'd0);
        push_block(8'd255);
        push_block(8'hA5);
        pop_blocks(7'd0);
        pop_blocks(7'd1);
        push_block(8'h5A);
        pop_blocks(7'(fblm_pkg::MAX_POP));
        pop_blocks(7'd3);
        drain_results();
    endtask

    // Pops that are cut short by the count, then a pop that empties the list early.
    // Back-to-back commands are used here, so every word after the first arrives while the block is busy.
    task automatic test_pop_counts;
        gaps_on = 1'b0;
        push_block(8'h01);
        push_block(8'h02);
        push_block(8'h04);
        push_block(8'h08);
        push_block(8'h10);
        push_block(8'h20);
        pop_blocks(7'd2);
        pop_blocks(7'd0);
        pop_blocks(7'(fblm_pkg::MAX_POP));
        drain_results();
    endtask

    // Allocator-style traffic. Only blocks that are not already free get pushed, so
    // the list stays a proper chain and can run empty again. The push rate changes
    // in phases so that the list sometimes grows past the maximum pop count and
    // sometimes drains to nothing. Large counts test that the count is capped.
    task automatic test_random_allocation;
        int                  i;
        int                  push_pct;
        int                  idx;
        fblm_pkg::cmd_word_t w;
        push_pct = 50;
        for (i = 0; i < 340; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 30;
                    1: push_pct = 55;
                    default: push_pct = 85;
                endcase
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (i == 170)
                drain_results();
            if (list_depth < fblm_pkg::NUM_BLOCKS && $urandom_range(1, 100) <= push_pct)
            begin
                idx = $urandom_range(0, fblm_pkg::NUM_BLOCKS - 1);
                while (on_list[idx])
                    idx = (idx + 1) % fblm_pkg::NUM_BLOCKS;
                w.operation = fblm_pkg::OP_PUSH;
                w.block_index = idx[fblm_pkg::INDEX_W-1:0];
                w.pop_count = 7'($urandom_range(0, 127));
            end
            else
            begin
                w.operation = fblm_pkg::OP_POP;
                w.block_index = 8'($urandom);
                if ($urandom_range(0, 3) == 0)
                    w.pop_count = 7'($urandom_range(fblm_pkg::MAX_POP, 127));
                else
                    w.pop_count = 7'($urandom_range(0, 10));
            end
            send_word(w);
        end
        drain_results();
    endtask

    // The same block freed twice links to itself. A pop then returns that block
    // again and again until the capped count stops it. This loop can never be
    // undone, so the test runs after the allocator traffic.
    task automatic test_looped_list;
        gaps_on = 1'b0;
        push_block(8'h80);
        push_block(8'h80);
        pop_blocks(7'h7F);
        drain_results();
    endtask

    // Unrestricted words: duplicate pushes, arbitrary counts, and random bit patterns.
    task automatic test_random_noise;
        int                  i;
        fblm_pkg::cmd_word_t w;
        gaps_on = 1'b1;
        for (i = 0; i < 60; i++)
        begin
            w = fblm_pkg::cmd_word_t'(16'($urandom));
            send_word(w);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        shadow_head = '0;
        shadow_head_valid = 1'b0;
        list_depth = 0;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        gaps_on = 1'b0;
        for (int i = 0; i < fblm_pkg::NUM_BLOCKS; i++)
        begin
            shadow_links[i] = '0;
            on_list[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_push_pop_order();
        test_pop_counts();
        test_random_allocation();
        test_looped_list();
        test_random_noise();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d pushes and %0d pops; checked %0d result words.",
                 pushes_sent, pops_sent, words_checked);
        $display("%0d pops found the list empty, and %0d were capped at %0d blocks.",
                 empty_pops, capped_pops, fblm_pkg::MAX_POP);
        if (mismatches == 0)
            $display("free_block_list_manager_test OK");
        else
            $display("free_block_list_manager_test NOT OK");
        $finish;
    end

endmodule

[sim.f]
design/fblm_pkg.sv
design/fblm_datapath.sv
design/fblm_controller.sv
design/free_block_list_manager.sv
tb/free_block_list_manager_test.sv
